@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the banner classifier rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, ignored while reset is applied
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never be seen on a rising edge outside reset
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

@@ hw/rtl/bsc_pkg.sv @@
// ----------------------------------------------------------------------------
// bsc_pkg
// signature tables, identity codes and shared types of the banner classifier
// ----------------------------------------------------------------------------
package bsc_pkg;

	localparam int NUM_OPEN = 10;
	localparam int NUM_SYST = 8;
	localparam int NUM_PATS = NUM_OPEN + NUM_SYST;

	// longest signature in bytes; older bytes never take part in a compare
	localparam int SIG_BYTES  = 29;
	localparam int HIST_BYTES = SIG_BYTES - 1;

	localparam logic [2:0] OS_UNIX = 3'd0;
	localparam logic [2:0] OS_VMS  = 3'd1;
	localparam logic [2:0] OS_MAC  = 3'd2;
	localparam logic [2:0] OS_DOS  = 3'd3;
	localparam logic [2:0] OS_NT   = 3'd4;

	localparam logic [3:0] SRV_UNKNOWN = 4'd0;
	localparam logic [3:0] SRV_VMS30   = 4'd1;
	localparam logic [3:0] SRV_VMSMN   = 4'd2;
	localparam logic [3:0] SRV_MACVT   = 4'd3;
	localparam logic [3:0] SRV_MACNCSA = 4'd4;
	localparam logic [3:0] SRV_MACFTPD = 4'd5;
	localparam logic [3:0] SRV_DOSQ    = 4'd6;
	localparam logic [3:0] SRV_NT      = 4'd7;
	localparam logic [3:0] SRV_UTREE   = 4'd8;
	localparam logic [3:0] SRV_NSLTREE = 4'd9;

	// text right aligned: byte j holds the j-th character back from the end,
	// zero bytes above the text mean "don't care"
	typedef logic [8*SIG_BYTES-1:0] sig_text_t;

	localparam sig_text_t SIG_TEXT [NUM_PATS] = '{
		sig_text_t'({"Multi", "Net FTP Server Process"}),
		sig_text_t'({"Versa", "Term FTP Server"}),
		sig_text_t'({"Macintosh Resident", " FTP server"}),
		sig_text_t'({"Peter's Macintosh FTP", " daemon"}),
		sig_text_t'({"Win", "QVT"}),
		sig_text_t'({"Windows", " NT FTP Server"}),
		sig_text_t'({"NSL Uni", "Tree"}),
		sig_text_t'({"NSL UNI", "TREE"}),
		sig_text_t'({"Uni", "Tree"}),
		sig_text_t'({"UNI", "TREE"}),
		sig_text_t'({"Uni", "Tree"}),
		sig_text_t'({"UNI", "TREE"}),
		sig_text_t'("UNIX"),
		sig_text_t'({"215 VMS Multi", "Net"}),
		sig_text_t'("215 VMS"),
		sig_text_t'("200 VMS"),
		sig_text_t'("215 MACOS Peter's Server"),
		sig_text_t'({"Windows", "_NT"})
	};

	localparam logic [2:0] SIG_SYS [NUM_PATS] = '{
		OS_VMS, OS_MAC, OS_MAC, OS_MAC, OS_DOS, OS_NT,
		OS_UNIX, OS_UNIX, OS_UNIX, OS_UNIX,
		OS_UNIX, OS_UNIX, OS_UNIX, OS_VMS, OS_VMS, OS_VMS, OS_MAC, OS_NT
	};

	localparam logic [3:0] SIG_SRV [NUM_PATS] = '{
		SRV_VMSMN, SRV_MACVT, SRV_MACNCSA, SRV_MACFTPD, SRV_DOSQ, SRV_NT,
		SRV_NSLTREE, SRV_NSLTREE, SRV_UTREE, SRV_UTREE,
		SRV_UNKNOWN, SRV_UNKNOWN, SRV_UNKNOWN, SRV_VMSMN, SRV_VMSMN, SRV_VMS30,
		SRV_MACFTPD, SRV_NT
	};

	// one step of the input stage: the held beat moves on this cycle
	typedef struct packed {
		logic adv;
		logic last_beat;
	} bsc_step_t;

endpackage

@@ hw/rtl/bsc_match.sv @@
// ----------------------------------------------------------------------------
// bsc_match
// byte history, parallel signature compares and sticky found bits
// ----------------------------------------------------------------------------
module bsc_match import bsc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  bsc_step_t           step,
	input  logic [7:0]          byte_s1,
	output logic [NUM_PATS-1:0] found_all
);

	logic [7:0]          hist_q [HIST_BYTES];
	logic [NUM_PATS-1:0] found_q;
	logic [NUM_PATS-1:0] hit;
	logic [7:0]          win [SIG_BYTES];

	// newest byte first
	always_comb begin
		win[0] = byte_s1;
		for (int j = 1; j < SIG_BYTES; j++) begin
			win[j] = hist_q[j-1];
		end
	end

	always_comb begin
		for (int p = 0; p < NUM_PATS; p++) begin
			hit[p] = 1'b1;
			for (int j = 0; j < SIG_BYTES; j++) begin
				if (SIG_TEXT[p][8*j +: 8] != 8'h00 && win[j] != SIG_TEXT[p][8*j +: 8]) begin
					hit[p] = 1'b0;
				end
			end
		end
	end

	assign found_all = found_q | hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < HIST_BYTES; j++) begin
				hist_q[j] <= 8'h00;
			end
			found_q <= '0;
		end else if (step.adv) begin
			if (step.last_beat) begin
				// nothing carries over into the next reply
				for (int j = 0; j < HIST_BYTES; j++) begin
					hist_q[j] <= 8'h00;
				end
				found_q <= '0;
			end else begin
				hist_q[0] <= byte_s1;
				for (int j = 1; j < HIST_BYTES; j++) begin
					hist_q[j] <= hist_q[j-1];
				end
				found_q <= found_all;
			end
		end
	end

endmodule

@@ hw/rtl/bsc_resolve.sv @@
// ----------------------------------------------------------------------------
// bsc_resolve
// winner pick, per-host identity table and result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bsc_resolve import bsc_pkg::*; #(
	parameter int NUM_HOSTS = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bsc_step_t           step,
	input  logic                func_s1,
	input  logic                host_s1,
	input  logic [NUM_PATS-1:0] found_all,
	input  logic                m_tready,
	output logic                m_tvalid,
	output logic                matched,
	output logic [2:0]          system_code,
	output logic [3:0]          server_code
);

	localparam int HOST_W = (NUM_HOSTS > 1) ? $clog2(NUM_HOSTS) : 1;

	logic [2:0]        sys_tab_q [NUM_HOSTS];
	logic [3:0]        srv_tab_q [NUM_HOSTS];
	logic [HOST_W-1:0] hidx;
	logic              hit_any;
	logic [2:0]        w_sys;
	logic [3:0]        w_srv;
	logic [2:0]        cur_sys;
	logic [3:0]        cur_srv;
	logic [2:0]        nxt_sys;
	logic [3:0]        nxt_srv;
	logic              valid_q;
	logic              matched_q;
	logic [2:0]        sys_q;
	logic [3:0]        srv_q;

	// a single host folds every reply onto entry zero
	assign hidx = (NUM_HOSTS > 1) ? HOST_W'(host_s1) : '0;

	// lowest index of the selected table wins
	always_comb begin
		hit_any = 1'b0;
		w_sys   = OS_UNIX;
		w_srv   = SRV_UNKNOWN;
		for (int p = NUM_PATS - 1; p >= 0; p--) begin
			if (found_all[p] && ((p >= NUM_OPEN) == func_s1)) begin
				hit_any = 1'b1;
				w_sys   = SIG_SYS[p];
				w_srv   = SIG_SRV[p];
			end
		end
	end

	assign cur_sys = sys_tab_q[hidx];
	assign cur_srv = srv_tab_q[hidx];

	always_comb begin
		nxt_sys = cur_sys;
		nxt_srv = cur_srv;
		if (hit_any) begin
			nxt_sys = w_sys;
			// a system reply keeps the server unless the system moved or it names one
			if (!func_s1 || w_sys != cur_sys || w_srv != SRV_UNKNOWN) begin
				nxt_srv = w_srv;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int h = 0; h < NUM_HOSTS; h++) begin
				sys_tab_q[h] <= OS_UNIX;
				srv_tab_q[h] <= SRV_UNKNOWN;
			end
			valid_q   <= 1'b0;
			matched_q <= 1'b0;
			sys_q     <= OS_UNIX;
			srv_q     <= SRV_UNKNOWN;
		end else if (step.adv && step.last_beat) begin
			sys_tab_q[hidx] <= nxt_sys;
			srv_tab_q[hidx] <= nxt_srv;
			valid_q         <= 1'b1;
			matched_q       <= hit_any;
			sys_q           <= nxt_sys;
			srv_q           <= nxt_srv;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	assign m_tvalid    = valid_q;
	assign matched     = matched_q;
	assign system_code = sys_q;
	assign server_code = srv_q;

	`ASSERT_CLK(a_last_gives_result, step.adv && step.last_beat |=> valid_q,
		"final byte did not produce a result")
	`ASSERT_NEVER(a_no_overwrite, step.adv && step.last_beat && valid_q && !m_tready,
		"result overwritten while still waiting")
	`ASSERT_CLK(a_codes_in_range, valid_q |-> (sys_q <= OS_NT && srv_q <= SRV_NSLTREE),
		"identity code out of range")
	`ASSERT_CLK(a_result_only_on_last,
		!(step.adv && step.last_beat) |=> $stable(sys_q) && $stable(srv_q) && $stable(matched_q),
		"result changed without a final byte")

endmodule

@@ hw/rtl/banner_signature_classifier_top.sv @@
// ----------------------------------------------------------------------------
// banner_signature_classifier_top
// matches reply text against greeting and system-reply signatures and keeps
// the identity of each remote host
//
//   channel  dir  tdata                        tuser               tlast
//   s_*      in   [7:0] text_byte              [0] func [1] host   last
//   m_*      out  [2:0] system_code            [0] matched         -
//                 [6:3] server_code [7] zero
//
// one beat per cycle in while no final beat waits; a beat is held in the input
// register and the compares of it and the 28 bytes before it run between that
// register and the result register, loaded as the final beat moves on.
// a waiting result stalls only the next final beat; other beats keep flowing.
// reset clears history, found bits, host table and result valid at once.
// ----------------------------------------------------------------------------
module banner_signature_classifier_top import bsc_pkg::*; #(
	parameter int NUM_HOSTS = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] text_byte
	input  logic [1:0] s_tuser,   // [0] func, [1] host
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [2:0] system_code, [6:3] server_code, [7] zero
	output logic       m_tuser    // [0] matched
);

	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                func_s1;
	logic                host_s1;
	logic                last_s1;
	bsc_step_t           step;
	logic [NUM_PATS-1:0] found_all;
	logic [2:0]          system_code;
	logic [3:0]          server_code;

	// a final beat waits only while the result register is still full
	assign step.adv       = valid_s1 && !(last_s1 && m_tvalid && !m_tready);
	assign step.last_beat = last_s1;
	assign s_tready       = !valid_s1 || step.adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (step.adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			func_s1 <= s_tuser[0];
			host_s1 <= s_tuser[1];
			last_s1 <= s_tlast;
		end
	end

	bsc_match u_match (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.byte_s1   (byte_s1),
		.found_all (found_all)
	);

	bsc_resolve #(
		.NUM_HOSTS (NUM_HOSTS)
	) u_resolve (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.func_s1     (func_s1),
		.host_s1     (host_s1),
		.found_all   (found_all),
		.m_tready    (m_tready),
		.m_tvalid    (m_tvalid),
		.matched     (m_tuser),
		.system_code (system_code),
		.server_code (server_code)
	);

	assign m_tdata = {1'b0, server_code, system_code};

endmodule

@@ tb/banner_classifier_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// banner_classifier_checker
// watches both stream channels of the banner classifier, keeps its own model
// of the byte history, found signatures and host identity table, and compares
// every result beat with the identity predicted for the oldest open reply
// ----------------------------------------------------------------------------
module banner_classifier_checker import bsc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] text_byte
	input  logic [1:0] s_tuser,   // [0] func, [1] host
	input  logic       s_tlast,
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,   // [2:0] system_code, [6:3] server_code, [7] zero
	input  logic       m_tuser,   // [0] matched
	output int         fail_count,
	output int         outstanding,
	output int         checked,
	output int         hits
);

	localparam int WIN_BYTES   = 32;
	localparam int NUM_HOSTS   = 2;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic       matched;
		logic [2:0] system_code;
		logic [3:0] server_code;
	} host_id_t;

	localparam logic [2:0] PAT_SYS [NUM_PATS] = '{
		OS_VMS, OS_MAC, OS_MAC, OS_MAC, OS_DOS, OS_NT,
		OS_UNIX, OS_UNIX, OS_UNIX, OS_UNIX,
		OS_UNIX, OS_UNIX, OS_UNIX, OS_VMS, OS_VMS, OS_VMS, OS_MAC, OS_NT
	};

	localparam logic [3:0] PAT_SRV [NUM_PATS] = '{
		SRV_VMSMN, SRV_MACVT, SRV_MACNCSA, SRV_MACFTPD, SRV_DOSQ, SRV_NT,
		SRV_NSLTREE, SRV_NSLTREE, SRV_UTREE, SRV_UTREE,
		SRV_UNKNOWN, SRV_UNKNOWN, SRV_UNKNOWN, SRV_VMSMN, SRV_VMSMN, SRV_VMS30,
		SRV_MACFTPD, SRV_NT
	};

	string               pat_text [NUM_PATS];
	logic [7:0]          recent [WIN_BYTES];
	logic [NUM_PATS-1:0] seen;
	logic [2:0]          sys_of [NUM_HOSTS];
	logic [3:0]          srv_of [NUM_HOSTS];
	host_id_t            expected_ids [$];
	int                  n_fail;
	int                  n_checked;
	int                  n_hits;

	function automatic string pattern(int p);
		string head;
		string tail;
		tail = "";
		case (p)
			0:  begin head = "Multi"; tail = "Net FTP Server Process"; end
			1:  begin head = "Versa"; tail = "Term FTP Server"; end
			2:  begin head = "Macintosh Resident"; tail = " FTP server"; end
			3:  begin head = "Peter's Macintosh FTP"; tail = " daemon"; end
			4:  begin head = "Win"; tail = "QVT"; end
			5:  begin head = "Windows"; tail = " NT FTP Server"; end
			6:  begin head = "NSL Uni"; tail = "Tree"; end
			7:  begin head = "NSL UNI"; tail = "TREE"; end
			8:  begin head = "Uni"; tail = "Tree"; end
			9:  begin head = "UNI"; tail = "TREE"; end
			10: begin head = "Uni"; tail = "Tree"; end
			11: begin head = "UNI"; tail = "TREE"; end
			12: head = "UNIX";
			13: begin head = "215 VMS Multi"; tail = "Net"; end
			14: head = "215 VMS";
			15: head = "200 VMS";
			16: head = "215 MACOS Peter's Server";
			default: begin head = "Windows"; tail = "_NT"; end
		endcase
		return {head, tail};
	endfunction

	initial begin
		for (int p = 0; p < NUM_PATS; p++)
			pat_text[p] = pattern(p);
	end

	// signature sits at the newest end of the history
	function automatic bit ends_with(string s);
		int n;
		n = s.len();
		if (n == 0 || n > WIN_BYTES)
			return 1'b0;
		for (int k = 0; k < n; k++)
			if (recent[WIN_BYTES-n+k] != s[k])
				return 1'b0;
		return 1'b1;
	endfunction

	task automatic take_text_byte(input logic func, input logic host, input logic [7:0] b,
		input logic last);
		int first;
		int cnt;
		int winner;
		int h;
		host_id_t r;
		for (int i = 0; i < WIN_BYTES - 1; i++)
			recent[i] = recent[i+1];
		recent[WIN_BYTES-1] = b;
		for (int p = 0; p < NUM_PATS; p++)
			if (ends_with(pat_text[p]))
				seen[p] = 1'b1;
		if (last) begin
			h = host % NUM_HOSTS;
			first = func ? NUM_OPEN : 0;
			cnt = func ? NUM_SYST : NUM_OPEN;
			winner = -1;
			for (int p = first; p < first + cnt; p++)
				if (seen[p] && winner < 0)
					winner = p;
			if (winner >= 0) begin
				// a system reply keeps the server unless the system moved or it names one
				if (!func || PAT_SYS[winner] != sys_of[h] || PAT_SRV[winner] != SRV_UNKNOWN)
					srv_of[h] = PAT_SRV[winner];
				sys_of[h] = PAT_SYS[winner];
			end
			r.matched = (winner >= 0);
			r.system_code = sys_of[h];
			r.server_code = srv_of[h];
			expected_ids.push_back(r);
			foreach (recent[i])
				recent[i] = 8'h00;
			seen = '0;
		end
	endtask

	task automatic check_result_beat();
		host_id_t want;
		n_checked++;
		if (expected_ids.size() == 0) begin
			n_fail++;
			if (n_fail <= MAX_REPORTS)
				$display("%0t: result beat with no open reply: matched=%0d system=%0d server=%0d",
					$time, m_tuser, m_tdata[2:0], m_tdata[6:3]);
		end else begin
			want = expected_ids.pop_front();
			if (want.matched)
				n_hits++;
			if (m_tuser !== want.matched || m_tdata[2:0] !== want.system_code ||
				m_tdata[6:3] !== want.server_code || m_tdata[7] !== 1'b0) begin
				n_fail++;
				if (n_fail <= MAX_REPORTS)
					$display({"%0t: result %0d expected matched=%0d system=%0d server=%0d,",
						" got matched=%0d system=%0d server=%0d pad=%0d"},
						$time, n_checked, want.matched, want.system_code, want.server_code,
						m_tuser, m_tdata[2:0], m_tdata[6:3], m_tdata[7]);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (recent[i])
				recent[i] = 8'h00;
			seen = '0;
			foreach (sys_of[i]) begin
				sys_of[i] = OS_UNIX;
				srv_of[i] = SRV_UNKNOWN;
			end
			expected_ids.delete();
			n_fail = 0;
			n_checked = 0;
			n_hits = 0;
			fail_count <= 0;
			outstanding <= 0;
			checked <= 0;
			hits <= 0;
		end else begin
			// a result leaves only after its last beat has passed the input and result registers, so check first
			if (m_tvalid && m_tready)
				check_result_beat();
			if (s_tvalid && s_tready)
				take_text_byte(s_tuser[0], s_tuser[1], s_tdata, s_tlast);
			fail_count <= n_fail;
			outstanding <= expected_ids.size();
			checked <= n_checked;
			hits <= n_hits;
		end
	end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// stream stimulus for the banner classifier: directed replies for the edge
// cases, then random replies built around the signature texts with noise,
// broken and overlong replies, random gaps on both sides and one long output
// hold-off; the checker beside the block does all prediction
// ----------------------------------------------------------------------------
module tb import bsc_pkg::*;;

	localparam logic GREETING     = 1'b0;
	localparam logic SYST_REPLY   = 1'b1;
	localparam int   TARGET_BYTES = 600;
	localparam int   MIN_REPLIES  = 20;
	localparam int   HOLD_AT      = 15;
	localparam int   HOLD_CYCLES  = 300;

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;   // [7:0] text_byte
	logic [1:0] s_tuser;   // [0] func, [1] host
	logic       s_tlast;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;   // [2:0] system_code, [6:3] server_code, [7] zero
	logic       m_tuser;   // [0] matched

	int         fail_count;
	int         outstanding;
	int         checked;
	int         hits;

	logic [7:0] reply_buf [$];
	int         bytes_sent;
	int         replies_sent;
	bit         fast_send;

	banner_signature_classifier_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	banner_classifier_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.fail_count  (fail_count),
		.outstanding (outstanding),
		.checked     (checked),
		.hits        (hits)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("timeout: handshakes stopped");
		$display("Regression FAIL");
		$finish;
	end

	// result side: random stalls, quiet stretches, one long hold-off
	initial begin
		int  stall;
		int  taken;
		bit  steady;
		taken = 0;
		steady = 1'b0;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 7) == 0)
				steady = !steady;
			stall = steady ? 0 : $urandom_range(0, 4);
			if (taken == HOLD_AT)
				stall = HOLD_CYCLES;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			taken++;
		end
	end

	function automatic void add_text(string s);
		for (int i = 0; i < s.len(); i++)
			reply_buf.push_back(s[i]);
	endfunction

	// package text is right aligned, first character in the highest byte
	function automatic void add_sig(int p);
		logic [7:0] c;
		for (int j = SIG_BYTES - 1; j >= 0; j--) begin
			c = SIG_TEXT[p][8*j +: 8];
			if (c != 8'h00)
				reply_buf.push_back(c);
		end
	endfunction

	// mostly characters taken from the signatures, to build near misses
	function automatic logic [7:0] noise_byte();
		int p;
		int j;
		logic [7:0] c;
		p = $urandom_range(0, NUM_PATS - 1);
		j = $urandom_range(0, SIG_BYTES - 1);
		c = SIG_TEXT[p][8*j +: 8];
		if (c == 8'h00 || $urandom_range(0, 2) == 0)
			c = 8'($urandom);
		return c;
	endfunction

	task automatic send_beat(input logic func, input logic host, input logic [7:0] b,
		input logic last);
		int gap;
		gap = fast_send ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= {host, func};
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
	endtask

	task automatic send_reply(input logic func, input logic host);
		for (int i = 0; i < reply_buf.size(); i++)
			send_beat(func, host, reply_buf[i], i == reply_buf.size() - 1);
		reply_buf.delete();
		replies_sent++;
		if ($urandom_range(0, 5) == 0)
			fast_send = !fast_send;
	endtask

	initial begin
		int   p;
		int   start;
		int   kind;
		int   n_pre;
		int   w;
		logic func;
		s_tvalid <= 1'b0;
		s_tdata <= 8'h00;
		s_tuser <= 2'b00;
		s_tlast <= 1'b0;
		arst_n <= 1'b0;
		bytes_sent = 0;
		replies_sent = 0;
		fast_send = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one-byte replies at the byte extremes, no signature
		reply_buf.push_back(8'h00);
		send_reply(GREETING, 1'b0);
		reply_buf.push_back(8'hFF);
		send_reply(SYST_REPLY, 1'b1);
		// system reply with the stored system: server stays
		add_text("UNIX");
		send_reply(SYST_REPLY, 1'b1);
		add_text("Win");
		add_text("QVT");
		send_reply(GREETING, 1'b0);
		// system changes on a system reply: server drops to unknown
		add_text("UNIX");
		send_reply(SYST_REPLY, 1'b0);
		// signature split over two replies must not be found
		add_text("UN");
		send_reply(SYST_REPLY, 1'b0);
		add_text("IX");
		send_reply(SYST_REPLY, 1'b0);
		// zero byte inside a signature breaks it
		add_text("UN");
		reply_buf.push_back(8'h00);
		add_text("IX");
		send_reply(SYST_REPLY, 1'b0);

		while (bytes_sent < TARGET_BYTES || replies_sent < MIN_REPLIES) begin
			kind = $urandom_range(0, 9);
			p = $urandom_range(0, NUM_PATS - 1);
			// some replies run past the history window before the signature
			n_pre = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 4);
			repeat (n_pre) reply_buf.push_back(noise_byte());
			if (kind < 7) begin
				add_sig(p);
				if ($urandom_range(0, 3) == 0)
					add_sig($urandom_range(0, NUM_PATS - 1));
			end else if (kind < 9) begin
				start = reply_buf.size();
				add_sig(p);
				if ($urandom_range(0, 1) == 0)
					reply_buf[$urandom_range(start, reply_buf.size() - 1)] = noise_byte();
				else
					void'(reply_buf.pop_back());
			end
			repeat ($urandom_range(0, 3)) reply_buf.push_back(noise_byte());
			if (reply_buf.size() == 0)
				reply_buf.push_back(noise_byte());
			func = ($urandom_range(0, 4) == 0) ? 1'($urandom) : (p >= NUM_OPEN);
			send_reply(func, 1'($urandom));
		end
		s_tvalid <= 1'b0;
		s_tlast <= 1'b0;

		@(posedge clk);
		for (w = 0; w < 2000 && outstanding != 0; w++)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("sent %0d text bytes in %0d replies over both tables and hosts",
			bytes_sent, replies_sent);
		$display("checked %0d identity results, %0d with a signature hit, %0d still open",
			checked, hits, outstanding);
		if (fail_count == 0 && outstanding == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
